@@ hdl/utf8d_pkg.sv @@
package utf8d_pkg;

    localparam int unsigned BYTE_W = 8;
    localparam int unsigned CP_W   = 32;
    localparam int unsigned OWED_W = 3;
    localparam int unsigned LEAD_W = 4;

    localparam logic [BYTE_W-1:0] PAYLOAD_MASK_BASE = 8'h7f;
    localparam logic [BYTE_W-1:0] CONT_MASK         = 8'h3f;

    typedef struct packed {
        logic [CP_W-1:0]   acc;
        logic [OWED_W-1:0] owed;
    } dec_state_t;

    typedef struct packed {
        logic            emit;
        logic [CP_W-1:0] value;
    } dec_result_t;

    function automatic logic [LEAD_W-1:0] lead_ones(input logic [BYTE_W-1:0] b);
        logic [LEAD_W-1:0] n;
        logic              run;
        n   = '0;
        run = 1'b1;
        for (int i = BYTE_W - 1; i >= 0; i--)
        begin
            run = run & b[i];
            if (run)
            begin
                n = n + LEAD_W'(1);
            end
        end
        return n;
    endfunction

endpackage

@@ hdl/utf8d_ifs.sv @@
interface utf8d_byte_if;
    import utf8d_pkg::*;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] byte_in;

    modport source (output valid, output byte_in, input ready);
    modport sink (input valid, input byte_in, output ready);
endinterface

interface utf8d_cp_if;
    import utf8d_pkg::*;
    logic            valid;
    logic            ready;
    logic [CP_W-1:0] code_point;

    modport source (output valid, output code_point, input ready);
    modport sink (input valid, input code_point, output ready);
endinterface

@@ hdl/utf8d_step.sv @@
module utf8d_step
    import utf8d_pkg::*;
(
    input  logic [BYTE_W-1:0] byte_in,
    input  dec_state_t        st,
    output dec_state_t        st_next,
    output dec_result_t       res
);

    logic [LEAD_W-1:0] lead;
    logic [CP_W-1:0]   acc_shift;

    always_comb
    begin
        lead      = lead_ones(byte_in);
        acc_shift = {st.acc[CP_W-7:0], byte_in[5:0] & CONT_MASK[5:0]};
        st_next   = st;
        res.emit  = 1'b0;
        res.value = acc_shift;
        if (!byte_in[BYTE_W-1])
        begin
            // ascii clears any pending sequence
            st_next.acc  = '0;
            st_next.owed = '0;
            res.emit     = (byte_in != '0);
            res.value    = {{(CP_W-BYTE_W){1'b0}}, byte_in};
        end
        else if (lead == LEAD_W'(1) && st.owed != '0)
        begin
            st_next.acc  = acc_shift;
            st_next.owed = st.owed - OWED_W'(1);
            res.emit     = (st_next.owed == '0) && (acc_shift != '0);
        end
        else
        begin
            // lead byte, stray continuation, 0xfe and 0xff
            st_next.acc  = {{(CP_W-BYTE_W){1'b0}}, byte_in & (PAYLOAD_MASK_BASE >> lead)};
            st_next.owed = OWED_W'(lead - LEAD_W'(1));
        end
    end

endmodule

@@ hdl/utf8_stream_decoder_top.sv @@
// path: input register, combinational decode step, output register for the code point
// throughput: one byte per cycle, independent of output stalls as long as the sink takes
// results at that rate; a full output register holds the input stage
// reset: asynchronous, clears the decode state (accumulator and owed count) and both
// valid flags
module utf8_stream_decoder_top
    import utf8d_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    utf8d_byte_if.sink  byte_stream,
    utf8d_cp_if.source  char_stream
);

    logic              in_vld_reg;
    logic [BYTE_W-1:0] in_byte_reg;
    dec_state_t        st_reg;
    dec_state_t        st_next;
    dec_result_t       res;
    logic              out_vld_reg;
    logic [CP_W-1:0]   out_cp_reg;
    logic              adv;

    assign adv               = !out_vld_reg || char_stream.ready;
    assign byte_stream.ready = !in_vld_reg || adv;

    utf8d_step u_step
    (
        .byte_in (in_byte_reg),
        .st      (st_reg),
        .st_next (st_next),
        .res     (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
            st_reg      <= '0;
        end
        else
        begin
            if (byte_stream.ready)
            begin
                in_vld_reg <= byte_stream.valid;
            end
            if (adv)
            begin
                out_vld_reg <= in_vld_reg && res.emit;
                if (in_vld_reg)
                begin
                    st_reg <= st_next;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (byte_stream.ready && byte_stream.valid)
        begin
            in_byte_reg <= byte_stream.byte_in;
        end
        if (adv && in_vld_reg && res.emit)
        begin
            out_cp_reg <= res.value;
        end
    end

    assign char_stream.valid      = out_vld_reg;
    assign char_stream.code_point = out_cp_reg;

endmodule

@@ hdl/utf8d_checker.sv @@
module utf8d_checker
    import utf8d_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_ready,
    input logic [BYTE_W-1:0] byte_in,
    input logic              out_valid,
    input logic              out_ready,
    input logic [CP_W-1:0]   code_point
);

    // stalled result stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(code_point))
        else $error("result changed while stalled");

    // zero is never emitted
    a_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> code_point != '0)
        else $error("zero code point emitted");

    // ascii passes through the input and output registers when the output is free
    a_ascii: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && !byte_in[BYTE_W-1] && byte_in != '0
        ##1 (!out_valid || out_ready)
        |=> out_valid && code_point == {{(CP_W-BYTE_W){1'b0}}, $past(byte_in, 2)})
        else $error("ascii item not passed through");

endmodule

bind utf8_stream_decoder_top utf8d_checker u_checker
(
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (byte_stream.valid),
    .in_ready   (byte_stream.ready),
    .byte_in    (byte_stream.byte_in),
    .out_valid  (char_stream.valid),
    .out_ready  (char_stream.ready),
    .code_point (char_stream.code_point)
);

@@ bench/utf8_stream_decoder_top_tb.sv @@
`timescale 1ns / 100ps

module utf8_stream_decoder_top_tb;
    import utf8d_pkg::*;

    localparam int unsigned STALL_LIMIT = 2000;
    localparam int unsigned DRAIN_CYCLES = 12;

    typedef enum logic [1:0] {
        CP_PREDICTED,
        CP_NONE,
        CP_GIVEN
    } cp_origin_t;

    typedef struct packed {
        logic [BYTE_W-1:0] b;
        cp_origin_t        origin;
        logic [CP_W-1:0]   cp;
    } byte_item_t;

    logic clk = 1'b0;
    logic rst_n;

    utf8d_byte_if byte_if ();
    utf8d_cp_if   cp_if ();

    utf8_stream_decoder_top i_dut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .byte_stream (byte_if),
        .char_stream (cp_if)
    );

    always #4 clk = ~clk;

    // decoder state as predicted
    logic [CP_W-1:0]   pred_acc;
    logic [OWED_W-1:0] pred_owed;

    byte_item_t      pending_bytes[$];
    logic [CP_W-1:0] expected_cps[$];

    int unsigned src_idle_pct;
    int unsigned sink_idle_pct;
    int unsigned stall_cycles;
    int unsigned bytes_taken;
    int unsigned cps_checked;
    int unsigned cps_high;
    int unsigned mismatches;
    bit          running;

    // directed item table: utf-8 text plus the corner cases
    localparam int unsigned N_DIRECTED = 26;
    byte_item_t directed_rows [N_DIRECTED] = '{
        '{8'h41, CP_GIVEN,     32'h41},
        '{8'h7f, CP_GIVEN,     32'h7f},
        '{8'h00, CP_NONE,      32'h0},
        '{8'h80, CP_NONE,      32'h0},
        '{8'hc3, CP_NONE,      32'h0},
        '{8'ha9, CP_PREDICTED, 32'h0},
        '{8'he2, CP_NONE,      32'h0},
        '{8'h82, CP_NONE,      32'h0},
        '{8'hac, CP_PREDICTED, 32'h0},
        '{8'hf0, CP_NONE,      32'h0},
        '{8'h9f, CP_NONE,      32'h0},
        '{8'h98, CP_NONE,      32'h0},
        '{8'h80, CP_PREDICTED, 32'h0},
        '{8'hc0, CP_NONE,      32'h0},
        '{8'h80, CP_NONE,      32'h0},
        '{8'he2, CP_NONE,      32'h0},
        '{8'h41, CP_GIVEN,     32'h41},
        '{8'hfe, CP_NONE,      32'h0},
        '{8'hff, CP_NONE,      32'h0},
        '{8'hbf, CP_PREDICTED, 32'h0},
        '{8'hbf, CP_PREDICTED, 32'h0},
        '{8'hbf, CP_PREDICTED, 32'h0},
        '{8'hbf, CP_PREDICTED, 32'h0},
        '{8'hbf, CP_PREDICTED, 32'h0},
        '{8'hbf, CP_PREDICTED, 32'h0},
        '{8'hbf, CP_PREDICTED, 32'h0}
    };

    function automatic void decode_byte
    (
        input  logic [BYTE_W-1:0] b,
        output logic              emit,
        output logic [CP_W-1:0]   cp
    );
        int unsigned ones;
        ones = 0;
        for (int i = BYTE_W - 1; i >= 0; i--)
        begin
            if (b[i] && ones == BYTE_W - 1 - i)
            begin
                ones++;
            end
        end
        emit = 1'b0;
        cp   = '0;
        if (!b[BYTE_W-1])
        begin
            pred_acc  = '0;
            pred_owed = '0;
            cp        = CP_W'(b);
            emit      = (b != '0);
        end
        else if (ones == 1 && pred_owed != '0)
        begin
            pred_acc  = {pred_acc[CP_W-7:0], b[5:0] & CONT_MASK[5:0]};
            pred_owed = pred_owed - OWED_W'(1);
            if (pred_owed == '0 && pred_acc != '0)
            begin
                emit = 1'b1;
                cp   = pred_acc;
            end
        end
        else
        begin
            pred_acc  = CP_W'(b & (PAYLOAD_MASK_BASE >> ones));
            pred_owed = OWED_W'(ones - 1);
        end
    endfunction

    function automatic void push_byte(input logic [BYTE_W-1:0] b);
        pending_bytes.push_back('{b, CP_PREDICTED, '0});
    endfunction

    // mostly well-formed sequences, some cut short, some noise
    task automatic queue_random_text(input int unsigned n);
        int unsigned pushed;
        int unsigned pick;
        int unsigned len;
        int unsigned cut;
        logic [BYTE_W-1:0] lead;
        pushed = 0;
        while (pushed < n)
        begin
            pick = $urandom_range(99);
            if (pick < 20)
            begin
                push_byte(BYTE_W'($urandom_range(127)));
                pushed++;
            end
            else if (pick < 85)
            begin
                pick = $urandom_range(99);
                len  = (pick < 35) ? 2 : (pick < 65) ? 3 : (pick < 85) ? 4 :
                       (pick < 91) ? 5 : (pick < 95) ? 6 : (pick < 98) ? 7 : 8;
                lead = (8'hff << (8 - len)) | (8'($urandom) & (PAYLOAD_MASK_BASE >> len));
                cut  = len;
                if ($urandom_range(9) == 0)
                begin
                    cut = $urandom_range(len - 1, 1);
                end
                push_byte(lead);
                pushed++;
                for (int k = 1; k < cut; k++)
                begin
                    push_byte({2'b10, 6'($urandom)});
                    pushed++;
                end
            end
            else
            begin
                push_byte(8'($urandom));
                pushed++;
            end
        end
    endtask

    task automatic wait_drained();
        while (pending_bytes.size() != 0 || expected_cps.size() != 0)
        begin
            @(negedge clk);
        end
    endtask

    always @(posedge clk)
    begin : drive_and_check
        byte_item_t      cur;
        logic            emit;
        logic [CP_W-1:0] cp;
        logic [CP_W-1:0] want;
        bit              moved;
        if (!rst_n)
        begin
            byte_if.valid <= 1'b0;
            cp_if.ready   <= 1'b0;
        end
        else
        begin
            moved = 1'b0;
            if (byte_if.valid && byte_if.ready)
            begin
                moved = 1'b1;
                cur   = pending_bytes.pop_front();
                decode_byte(cur.b, emit, cp);
                bytes_taken++;
                case (cur.origin)
                    CP_PREDICTED:
                    begin
                        if (emit)
                        begin
                            expected_cps.push_back(cp);
                        end
                    end
                    CP_GIVEN:
                    begin
                        expected_cps.push_back(cur.cp);
                    end
                    default:
                    begin
                    end
                endcase
            end
            if (cp_if.valid && cp_if.ready)
            begin
                moved = 1'b1;
                if (expected_cps.size() == 0)
                begin
                    $display("%0t: unexpected code_point: expected none, actual %08h",
                             $time, cp_if.code_point);
                    mismatches++;
                end
                else
                begin
                    want = expected_cps.pop_front();
                    cps_checked++;
                    if (want[CP_W-1])
                    begin
                        cps_high++;
                    end
                    if (cp_if.code_point !== want)
                    begin
                        $display("%0t: code_point mismatch: expected %08h, actual %08h",
                                 $time, want, cp_if.code_point);
                        mismatches++;
                    end
                end
            end
            // hold an item that is offered but not yet taken
            if (!(byte_if.valid && !byte_if.ready))
            begin
                if (pending_bytes.size() != 0 && $urandom_range(99) >= src_idle_pct)
                begin
                    byte_if.valid   <= 1'b1;
                    byte_if.byte_in <= pending_bytes[0].b;
                end
                else
                begin
                    byte_if.valid <= 1'b0;
                end
            end
            cp_if.ready <= ($urandom_range(99) >= sink_idle_pct);
            if (running)
            begin
                if (moved)
                begin
                    stall_cycles = 0;
                end
                else
                begin
                    stall_cycles++;
                    if (stall_cycles >= STALL_LIMIT)
                    begin
                        $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
                        $display("utf8_stream_decoder_top_tb: errors");
                        $finish;
                    end
                end
            end
        end
    end

    initial
    begin
        rst_n           = 1'b0;
        byte_if.valid   = 1'b0;
        byte_if.byte_in = '0;
        cp_if.ready     = 1'b0;
        pred_acc        = '0;
        pred_owed       = '0;
        src_idle_pct    = 8;
        sink_idle_pct   = 60;
        stall_cycles    = 0;
        bytes_taken     = 0;
        cps_checked     = 0;
        cps_high        = 0;
        mismatches      = 0;
        running         = 1'b0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n   = 1'b1;
        running = 1'b1;

        foreach (directed_rows[i])
        begin
            pending_bytes.push_back(directed_rows[i]);
        end
        wait_drained();

        queue_random_text(200);
        wait_drained();

        src_idle_pct  = 60;
        sink_idle_pct = 8;
        queue_random_text(200);
        wait_drained();

        src_idle_pct  = 0;
        sink_idle_pct = 0;
        queue_random_text(150);
        wait_drained();

        repeat (DRAIN_CYCLES) @(posedge clk);
        running = 1'b0;
        if (expected_cps.size() != 0)
        begin
            $display("%0t: %0d code points never arrived, first expected %08h",
                     $time, expected_cps.size(), expected_cps[0]);
            mismatches++;
        end

        $display("decoded %0d bytes under three stall mixes, checked %0d code points",
                 bytes_taken, cps_checked);
        $display("%0d code points had bit 31 set, %0d mismatches", cps_high, mismatches);
        if (mismatches == 0)
        begin
            $display("utf8_stream_decoder_top_tb: clean");
        end
        else
        begin
            $display("utf8_stream_decoder_top_tb: errors");
        end
        $finish;
    end

endmodule
